@@ rtl/core/psca_pkg.sv @@
// Shared types and constants for the pump short-cycle alarm.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package psca_pkg;

    localparam int PRESCALE_W        = 10;
    localparam int LIMIT_W           = 16;
    localparam int COUNT_W           = 8;
    localparam int WINDOW_W          = 20;
    localparam int REPORT_W          = 16;
    localparam int CFG_DATA_W        = 20;
    localparam int CFG_IDX_W         = 2;
    localparam int SECONDS_WIDTH_DEF = 16;

    localparam logic [PRESCALE_W-1:0] TICKS_PER_SEC_RST = PRESCALE_W'(1000);
    localparam logic [LIMIT_W-1:0]    SHORT_LIMIT_RST   = LIMIT_W'(15);
    localparam logic [COUNT_W-1:0]    THRESHOLD_RST     = COUNT_W'(2);
    localparam logic [WINDOW_W-1:0]   WINDOW_TICKS_RST  = WINDOW_W'(60000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICKS_PER_SEC = 2'd0,
        CFG_SHORT_LIMIT   = 2'd1,
        CFG_THRESHOLD     = 2'd2,
        CFG_WINDOW_TICKS  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [PRESCALE_W-1:0] ticks_per_second;
        logic [LIMIT_W-1:0]    short_limit_seconds;
        logic [COUNT_W-1:0]    short_count_threshold;
        logic [WINDOW_W-1:0]   window_ticks;
    } t_cfg;

    typedef struct packed {
        logic                alarm;
        logic                running;
        logic                run_report_valid;
        logic [REPORT_W-1:0] run_report_seconds;
        logic                idle_report_valid;
        logic [REPORT_W-1:0] idle_report_seconds;
        logic [COUNT_W-1:0]  short_runs;
    } t_result;

endpackage

@@ rtl/core/psca_if.sv @@
// Valid/ready channel interfaces for the pump short-cycle alarm.
// Depends on psca_pkg for field widths.
`timescale 1ns / 1ps

interface psca_in_if;
    import psca_pkg::*;
    logic valid;
    logic ready;
    logic pump_running;
    logic alarm_clear;

    modport source (output valid, output pump_running, output alarm_clear, input ready);
    modport sink   (input valid, input pump_running, input alarm_clear, output ready);
endinterface

interface psca_out_if;
    import psca_pkg::*;
    logic                valid;
    logic                ready;
    logic                alarm;
    logic                running;
    logic                run_report_valid;
    logic [REPORT_W-1:0] run_report_seconds;
    logic                idle_report_valid;
    logic [REPORT_W-1:0] idle_report_seconds;
    logic [COUNT_W-1:0]  short_runs;

    modport source (output valid, output alarm, output running, output run_report_valid,
                    output run_report_seconds, output idle_report_valid,
                    output idle_report_seconds, output short_runs, input ready);
    modport sink   (input valid, input alarm, input running, input run_report_valid,
                    input run_report_seconds, input idle_report_valid,
                    input idle_report_seconds, input short_runs, output ready);
endinterface

@@ rtl/core/psca_core.sv @@
// Per-tick state update: run/idle timers, short-run count, window, alarm latch.
// Depends on psca_pkg.
`timescale 1ns / 1ps

module psca_core #(
    parameter int SECONDS_WIDTH = psca_pkg::SECONDS_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step_en,
    input  logic              i_pump_running,
    input  logic              i_alarm_clear,
    input  psca_pkg::t_cfg    i_cfg,
    output psca_pkg::t_result o_result
);
    import psca_pkg::*;

    localparam int CMP_W = (SECONDS_WIDTH > REPORT_W) ? SECONDS_WIDTH : REPORT_W;

    logic                     r_running;
    logic [PRESCALE_W-1:0]    r_sec_ticks;
    logic [SECONDS_WIDTH-1:0] r_run_seconds;
    logic [SECONDS_WIDTH-1:0] r_idle_seconds;
    logic [WINDOW_W-1:0]      r_win_ticks;
    logic [COUNT_W-1:0]       r_short_count;
    logic                     r_alarm;

    logic                     n_running;
    logic [PRESCALE_W-1:0]    n_sec_ticks;
    logic [SECONDS_WIDTH-1:0] n_run_seconds;
    logic [SECONDS_WIDTH-1:0] n_idle_seconds;
    logic [WINDOW_W-1:0]      n_win_ticks;
    logic [COUNT_W-1:0]       n_short_count;
    logic                     n_alarm;

    logic                     w_start;
    logic                     w_stop;
    logic [PRESCALE_W-1:0]    w_sec_inc;
    logic [PRESCALE_W-1:0]    w_sec_phase;
    logic                     w_sec_hit;
    logic [WINDOW_W-1:0]      w_win_inc;
    logic [CMP_W-1:0]         w_run_ext;
    logic [CMP_W-1:0]         w_idle_ext;
    logic [CMP_W-1:0]         w_limit_ext;
    logic [COUNT_W-1:0]       w_count_upd;
    logic [SECONDS_WIDTH-1:0] w_run_plus;
    logic [SECONDS_WIDTH-1:0] w_idle_plus;

    assign w_start = i_pump_running && !r_running;
    assign w_stop  = !i_pump_running && r_running;

    // saturating tick counters
    assign w_sec_inc = (r_sec_ticks == '1) ? r_sec_ticks : r_sec_ticks + 1'b1;
    assign w_win_inc = (r_win_ticks == '1) ? r_win_ticks : r_win_ticks + 1'b1;

    // prescaler restarts on any transition before the compare
    assign w_sec_phase = (w_start || w_stop) ? '0 : w_sec_inc;
    assign w_sec_hit   = (w_sec_phase >= i_cfg.ticks_per_second);

    assign w_run_plus  = (r_run_seconds == '1)  ? r_run_seconds  : r_run_seconds + 1'b1;
    assign w_idle_plus = (r_idle_seconds == '1) ? r_idle_seconds : r_idle_seconds + 1'b1;

    assign w_run_ext   = CMP_W'(r_run_seconds);
    assign w_idle_ext  = CMP_W'(r_idle_seconds);
    assign w_limit_ext = CMP_W'(i_cfg.short_limit_seconds);

    assign w_count_upd = (w_stop && (w_run_ext <= w_limit_ext) && (r_short_count != '1))
                         ? r_short_count + 1'b1 : r_short_count;

    always_comb begin
        n_running      = i_pump_running;
        n_sec_ticks    = w_sec_hit ? '0 : w_sec_phase;
        n_run_seconds  = r_run_seconds;
        n_idle_seconds = r_idle_seconds;
        if (i_pump_running) begin
            if (w_start) begin
                n_idle_seconds = '0;
            end
            if (w_sec_hit) begin
                n_run_seconds = w_run_plus;
            end
        end else begin
            if (w_stop) begin
                n_run_seconds = '0;
            end
            if (w_sec_hit) begin
                n_idle_seconds = w_idle_plus;
            end
        end

        n_win_ticks   = w_win_inc;
        n_short_count = w_count_upd;
        if (w_win_inc >= i_cfg.window_ticks) begin
            n_win_ticks   = '0;
            n_short_count = '0;
        end

        n_alarm = r_alarm || (n_short_count >= i_cfg.short_count_threshold);
        if (i_alarm_clear) begin
            n_alarm = 1'b0;
        end
    end

    always_comb begin
        o_result                     = '0;
        o_result.alarm               = n_alarm;
        o_result.running             = n_running;
        o_result.run_report_valid    = w_stop;
        o_result.idle_report_valid   = w_start;
        o_result.short_runs          = n_short_count;
        if (w_stop) begin
            o_result.run_report_seconds = (w_run_ext > CMP_W'({REPORT_W{1'b1}}))
                                          ? {REPORT_W{1'b1}} : w_run_ext[REPORT_W-1:0];
        end
        if (w_start) begin
            o_result.idle_report_seconds = (w_idle_ext > CMP_W'({REPORT_W{1'b1}}))
                                           ? {REPORT_W{1'b1}} : w_idle_ext[REPORT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running      <= 1'b0;
            r_sec_ticks    <= '0;
            r_run_seconds  <= '0;
            r_idle_seconds <= '0;
            r_win_ticks    <= '0;
            r_short_count  <= '0;
            r_alarm        <= 1'b0;
        end else if (i_step_en) begin
            r_running      <= n_running;
            r_sec_ticks    <= n_sec_ticks;
            r_run_seconds  <= n_run_seconds;
            r_idle_seconds <= n_idle_seconds;
            r_win_ticks    <= n_win_ticks;
            r_short_count  <= n_short_count;
            r_alarm        <= n_alarm;
        end
    end

`ifndef SYNTHESIS
    a_one_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_result.run_report_valid && o_result.idle_report_valid))
        else $error("run and idle report in the same tick");

    a_running_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step_en |=> (r_running == $past(i_pump_running)))
        else $error("running state does not follow the pump level");

    a_clear_wins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step_en && i_alarm_clear) |=> !r_alarm)
        else $error("alarm survived a clear");

    a_idle_no_run_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_run_seconds == '0))
        else $error("run timer nonzero while idle");
`endif

endmodule

@@ rtl/core/pump_short_cycle_alarm.sv @@
// Top level of the pump short-cycle alarm: config registers, input and result stages.
// Depends on psca_pkg, psca_if (psca_in_if, psca_out_if) and psca_core.
`timescale 1ns / 1ps
//
//  Channel   | Direction | Handshake     | Payload
//  ----------+-----------+---------------+------------------------------------------------
//  i_in      | in        | valid / ready | pump_running, alarm_clear (one tick)
//  o_out     | out       | valid / ready | alarm, running, run/idle reports, short_runs
//  i_cfg_*   | in        | write enable  | i_cfg_idx selects register, i_cfg_data value
//
//  One transaction per cycle is sustained while o_out.ready stays high. From input
//  acceptance to result valid a tick passes the input register, then the state update in
//  psca_core feeding the result register.
//  Synchronous active-low reset clears the timers, the short count, the alarm, all valid
//  flags and restores register defaults. When the result stage is stalled the input
//  stage still takes one more transaction, then ready drops until the result drains.

module pump_short_cycle_alarm #(
    parameter int SECONDS_WIDTH = psca_pkg::SECONDS_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    psca_in_if.sink                             i_in,
    psca_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [psca_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [psca_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import psca_pkg::*;

    // configuration registers
    t_cfg    r_cfg;

    // input stage
    logic    r_s1_valid;
    logic    r_s1_pump;
    logic    r_s1_clear;

    // result stage
    logic    r_out_valid;
    t_result r_out;

    t_result w_result;
    logic    w_advance;
    logic    w_in_take;

    // the tick in the input stage moves on when the result slot is free or being drained
    assign w_advance = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || w_advance;
    assign w_in_take  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_second      <= TICKS_PER_SEC_RST;
            r_cfg.short_limit_seconds   <= SHORT_LIMIT_RST;
            r_cfg.short_count_threshold <= THRESHOLD_RST;
            r_cfg.window_ticks          <= WINDOW_TICKS_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TICKS_PER_SEC: r_cfg.ticks_per_second      <= i_cfg_data[PRESCALE_W-1:0];
                CFG_SHORT_LIMIT:   r_cfg.short_limit_seconds   <= i_cfg_data[LIMIT_W-1:0];
                CFG_THRESHOLD:     r_cfg.short_count_threshold <= i_cfg_data[COUNT_W-1:0];
                CFG_WINDOW_TICKS:  r_cfg.window_ticks          <= i_cfg_data[WINDOW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_s1_valid <= 1'b1;
            end else if (w_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_pump  <= i_in.pump_running;
            r_s1_clear <= i_in.alarm_clear;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    psca_core #(
        .SECONDS_WIDTH (SECONDS_WIDTH)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step_en      (w_advance),
        .i_pump_running (r_s1_pump),
        .i_alarm_clear  (r_s1_clear),
        .i_cfg          (r_cfg),
        .o_result       (w_result)
    );

    assign o_out.valid               = r_out_valid;
    assign o_out.alarm               = r_out.alarm;
    assign o_out.running             = r_out.running;
    assign o_out.run_report_valid    = r_out.run_report_valid;
    assign o_out.run_report_seconds  = r_out.run_report_seconds;
    assign o_out.idle_report_valid   = r_out.idle_report_valid;
    assign o_out.idle_report_seconds = r_out.idle_report_seconds;
    assign o_out.short_runs          = r_out.short_runs;

endmodule

@@ verif/testbench.sv @@
// Self-checking bench for pump_short_cycle_alarm: directed and random tick streams.
// Depends on psca_pkg, psca_if (psca_in_if, psca_out_if) and the RTL top level.
`timescale 1ns / 1ps

module testbench;
    import psca_pkg::*;

    // About 1100 ticks are queued in total; the limit leaves wide margin for gaps and stalls.
    localparam int unsigned MAX_CYCLES = 200_000;
    localparam int          MAX_WAIT   = 13;

    typedef struct packed {
        logic pump;
        logic clear;
    } t_tick;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    t_cfg_idx              i_cfg_idx  = CFG_TICKS_PER_SEC;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    psca_in_if  tick_ch ();
    psca_out_if res_ch ();

    pump_short_cycle_alarm DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (tick_ch),
        .o_out      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow copy of the block: registers and timer state
    // ------------------------------------------------------------------
    t_cfg                         cfg_shadow;
    logic                         pump_on;
    logic [PRESCALE_W-1:0]        sec_ticks;
    logic [SECONDS_WIDTH_DEF-1:0] run_secs;
    logic [SECONDS_WIDTH_DEF-1:0] idle_secs;
    logic [WINDOW_W-1:0]          win_ticks;
    logic [COUNT_W-1:0]           short_cnt;
    logic                         alarm_q;

    t_tick       tick_backlog[$];      // ticks waiting to be driven
    t_result     expected_results[$];  // predicted results, oldest first
    int unsigned failures = 0;
    bit          steady   = 1'b0;      // 1: no gaps and no stalls on either side

    // One tick of the pump timer. Order matters: prescaler/window advance first,
    // transition handling, second rollover, window expiry, alarm set, then clear.
    function automatic t_result step_tick(input t_tick t);
        t_result r;
        r = '0;
        if (sec_ticks != '1)
            sec_ticks++;
        if (win_ticks != '1)
            win_ticks++;

        if (t.pump) begin
            if (!pump_on) begin
                // idle gap ends; counter and report widths match, so the
                // counter's own saturation is the report's
                r.idle_report_valid   = 1'b1;
                r.idle_report_seconds = idle_secs;
                idle_secs             = '0;
                sec_ticks             = '0;
            end
            if (sec_ticks >= cfg_shadow.ticks_per_second) begin
                sec_ticks = '0;
                if (run_secs != '1)
                    run_secs++;
            end
        end else begin
            if (pump_on) begin
                r.run_report_valid   = 1'b1;
                r.run_report_seconds = run_secs;
                if (run_secs <= cfg_shadow.short_limit_seconds && short_cnt != '1)
                    short_cnt++;
                run_secs  = '0;
                sec_ticks = '0;
            end
            if (sec_ticks >= cfg_shadow.ticks_per_second) begin
                sec_ticks = '0;
                if (idle_secs != '1)
                    idle_secs++;
            end
        end
        pump_on = t.pump;

        if (win_ticks >= cfg_shadow.window_ticks) begin
            win_ticks = '0;
            short_cnt = '0;
        end

        if (short_cnt >= cfg_shadow.short_count_threshold)
            alarm_q = 1'b1;
        if (t.clear)
            alarm_q = 1'b0;

        r.alarm      = alarm_q;
        r.running    = pump_on;
        r.short_runs = short_cnt;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: one tick per transaction, random gap before the next
    // ------------------------------------------------------------------
    t_tick in_flight;
    int    send_gap;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            // predict at the edge the transaction is taken
            if (tick_ch.valid && tick_ch.ready)
                expected_results.push_back(step_tick(in_flight));
            if (!tick_ch.valid || tick_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    tick_ch.valid <= 1'b0;
                end else if (tick_backlog.size() != 0) begin
                    in_flight = tick_backlog.pop_front();
                    tick_ch.valid        <= 1'b1;
                    tick_ch.pump_running <= in_flight.pump;
                    tick_ch.alarm_clear  <= in_flight.clear;
                    send_gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
                end else begin
                    tick_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random stalls on ready, field-by-field compare
    // ------------------------------------------------------------------
    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
        end
    endtask

    int      take_wait;
    t_result want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            take_wait = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no tick outstanding");
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("alarm", want.alarm, res_ch.alarm);
                    check_field("running", want.running, res_ch.running);
                    check_field("run_report_valid", want.run_report_valid,
                                res_ch.run_report_valid);
                    check_field("run_report_seconds", want.run_report_seconds,
                                res_ch.run_report_seconds);
                    check_field("idle_report_valid", want.idle_report_valid,
                                res_ch.idle_report_valid);
                    check_field("idle_report_seconds", want.idle_report_seconds,
                                res_ch.idle_report_seconds);
                    check_field("short_runs", want.short_runs, res_ch.short_runs);
                end
                take_wait = steady ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (take_wait > 0) begin
                take_wait--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog
    int unsigned cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= MAX_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_TICKS_PER_SEC: cfg_shadow.ticks_per_second      = value[PRESCALE_W-1:0];
            CFG_SHORT_LIMIT:   cfg_shadow.short_limit_seconds   = value[LIMIT_W-1:0];
            CFG_THRESHOLD:     cfg_shadow.short_count_threshold = value[COUNT_W-1:0];
            CFG_WINDOW_TICKS:  cfg_shadow.window_ticks          = value[WINDOW_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_settings(input int unsigned tps, input int unsigned limit,
                                 input int unsigned thresh, input int unsigned window);
        write_reg(CFG_TICKS_PER_SEC, CFG_DATA_W'(tps));
        write_reg(CFG_SHORT_LIMIT, CFG_DATA_W'(limit));
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(thresh));
        write_reg(CFG_WINDOW_TICKS, CFG_DATA_W'(window));
    endtask

    task automatic queue_level(input logic pump, input int len, input logic clear);
        for (int k = 0; k < len; k++)
            tick_backlog.push_back('{pump, clear});
    endtask

    // Mostly clean run/idle segments of random length; some segments are noise.
    task automatic queue_traffic(input int count);
        int   left;
        int   seg_len;
        logic level;
        logic noisy;
        left  = count;
        level = 1'($urandom_range(0, 1));
        while (left > 0) begin
            seg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
                                                  : $urandom_range(1, 12);
            if (seg_len > left)
                seg_len = left;
            noisy = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < seg_len; k++)
                tick_backlog.push_back('{noisy ? 1'($urandom_range(0, 1)) : level,
                                         1'($urandom_range(0, 11) == 0)});
            level = ~level;
            left -= seg_len;
        end
    endtask

    // Block is idle once nothing is queued, driven or outstanding; then let the
    // two-stage pipeline settle before touching registers. Sampled on the falling
    // edge so the driver's updates at the rising edge are already visible.
    task automatic drain();
        do
            @(negedge i_clk);
        while (tick_backlog.size() != 0 || tick_ch.valid || expected_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        tick_ch.valid        = 1'b0;
        tick_ch.pump_running = 1'b0;
        tick_ch.alarm_clear  = 1'b0;
        res_ch.ready         = 1'b0;

        cfg_shadow = '{TICKS_PER_SEC_RST, SHORT_LIMIT_RST, THRESHOLD_RST, WINDOW_TICKS_RST};
        pump_on    = 1'b0;
        sec_ticks  = '0;
        run_secs   = '0;
        idle_secs  = '0;
        win_ticks  = '0;
        short_cnt  = '0;
        alarm_q    = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults straight out of reset
        queue_level(1'b0, 1, 1'b0);
        queue_level(1'b1, 2, 1'b0);
        queue_level(1'b0, 1, 1'b0);
        queue_level(1'b0, 1, 1'b1);
        queue_level(1'b1, 1, 1'b0);
        drain();

        // Directed: two-tick seconds, short means <= 1 s, alarm at two short runs
        load_settings(2, 1, 2, 1048575);
        queue_level(1'b0, 3, 1'b0);   // idle seconds build up
        queue_level(1'b1, 1, 1'b0);   // short run, idle report
        queue_level(1'b0, 3, 1'b0);   // first short run counted
        queue_level(1'b1, 6, 1'b0);   // long run, not counted
        queue_level(1'b0, 1, 1'b0);
        queue_level(1'b1, 2, 1'b0);
        queue_level(1'b0, 1, 1'b1);   // threshold hit and clear on the same tick
        queue_level(1'b0, 1, 1'b0);   // alarm latches again
        queue_level(1'b1, 1, 1'b1);   // clear while a run starts
        queue_level(1'b0, 1, 1'b0);
        drain();

        // Zero prescale, zero limit, zero threshold, zero window
        load_settings(0, 0, 0, 0);
        queue_traffic(100);
        drain();

        // Saturation: short count pins at 255, alarm only at full count
        load_settings(1, 65535, 255, 1048575);
        steady = 1'b1;
        for (int k = 0; k < 260; k++) begin
            queue_level(1'b1, 1, 1'b0);
            queue_level(1'b0, 1, 1'b0);
        end
        queue_level(1'b0, 2, 1'b1);
        drain();

        // Slow prescale with a one-tick window; a long run spans two seconds
        load_settings(7, 0, 255, 1);
        queue_level(1'b1, 20, 1'b0);
        steady = 1'b0;
        queue_traffic(60);
        drain();

        // Random phases with small settings so seconds, short runs and alarms all move
        for (int p = 0; p < 5; p++) begin
            load_settings($urandom_range(1, 6), $urandom_range(0, 4),
                          $urandom_range(1, 4), $urandom_range(20, 300));
            steady = (p == 2);
            queue_traffic(75);
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
